@@ sv/rap_pkg.sv @@
`default_nettype none

package rap_pkg;

    // Frame buffer sizing
    localparam int MAX_FRAME = 16;
    localparam int CNT_W     = $clog2(MAX_FRAME + 2);
    localparam int HDR_LEN   = 6;
    localparam int HDR_IDX_W = $clog2(HDR_LEN);

    // Field widths
    localparam int KIND_W    = 5;
    localparam int DIST_W    = 25;
    localparam int ACC_W     = 24;
    localparam int LEN_W     = 5;
    localparam int TICK_W    = 17;
    localparam int TMO_W     = 16;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    // Request kinds on the input tuser
    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_ISSUE = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Answer kinds
    localparam logic [KIND_W-1:0] K_SINGLE_COARSE = 5'd0;
    localparam logic [KIND_W-1:0] K_CONT_COARSE   = 5'd2;
    localparam logic [KIND_W-1:0] K_OUT_OF_RANGE  = 5'd4;
    localparam logic [KIND_W-1:0] K_MALFORMED     = 5'd5;
    localparam logic [KIND_W-1:0] K_LASER         = 5'd6;
    localparam logic [KIND_W-1:0] K_STOP          = 5'd7;
    localparam logic [KIND_W-1:0] K_STARTUP       = 5'd8;
    localparam logic [KIND_W-1:0] K_TOP_TAIL      = 5'd9;
    localparam logic [KIND_W-1:0] K_RANGE         = 5'd10;
    localparam logic [KIND_W-1:0] K_FREQ          = 5'd11;
    localparam logic [KIND_W-1:0] K_INTERVAL      = 5'd12;
    localparam logic [KIND_W-1:0] K_RESOLUTION    = 5'd13;
    localparam logic [KIND_W-1:0] K_MACHINE_NUM   = 5'd14;
    localparam logic [KIND_W-1:0] K_DIST_REVISED  = 5'd15;
    localparam logic [KIND_W-1:0] K_SENSOR_PARAM  = 5'd16;
    localparam logic [KIND_W-1:0] K_UNRECOGNIZED  = 5'd17;
    localparam logic [KIND_W-1:0] K_CHECKSUM      = 5'd18;
    localparam logic [KIND_W-1:0] K_TIMEOUT       = 5'd19;
    localparam logic [KIND_W-1:0] K_BUSY          = 5'd20;
    localparam logic [KIND_W-1:0] K_OVERFLOW      = 5'd21;

    // Header and text bytes
    localparam logic [7:0] B_ADDR_MEAS = 8'h80;
    localparam logic [7:0] B_ADDR_CFG  = 8'hFA;
    localparam logic [7:0] B_FN_06     = 8'h06;
    localparam logic [7:0] B_FN_04     = 8'h04;
    localparam logic [7:0] B_SINGLE    = 8'h82;
    localparam logic [7:0] B_CONT      = 8'h83;
    localparam logic [7:0] B_MACHINE   = 8'h84;
    localparam logic [7:0] B_PARAM     = 8'h81;
    localparam logic [7:0] B_CHAR_E    = 8'h45;
    localparam logic [7:0] B_CHAR_R    = 8'h52;
    localparam logic [7:0] B_DIGIT_0   = 8'h30;
    localparam logic [7:0] B_DIGIT_9   = 8'h39;

    // Frame positions and lengths
    localparam int MIN_LEN    = 4;
    localparam int ERR_LEN    = 6;
    localparam int LEN_COARSE = 11;
    localparam int LEN_FINE   = 12;
    localparam int DP_INT_LO  = 3;
    localparam int DP_INT_HI  = 5;
    localparam int DP_FRAC_LO = 7;
    localparam int DP_FRAC_HI = 10;

    // Acknowledgement frames identified by their first four bytes
    typedef struct packed {
        logic [7:0]        b0;
        logic [7:0]        b1;
        logic [7:0]        b2;
        logic [7:0]        b3;
        logic [KIND_W-1:0] kind;
    } t_ack;

    localparam int ACK_N = 9;
    localparam t_ack ACK_TABLE [ACK_N] = '{
        '{8'h80, 8'h06, 8'h85, 8'h01, K_LASER},
        '{8'h80, 8'h04, 8'h82, 8'hFA, K_STOP},
        '{8'hFA, 8'h04, 8'h8D, 8'h75, K_STARTUP},
        '{8'hFA, 8'h04, 8'h88, 8'h7A, K_TOP_TAIL},
        '{8'hFA, 8'h04, 8'h89, 8'h79, K_RANGE},
        '{8'hFA, 8'h04, 8'h8A, 8'h78, K_FREQ},
        '{8'hFA, 8'h04, 8'h85, 8'h7D, K_INTERVAL},
        '{8'hFA, 8'h04, 8'h8C, 8'h76, K_RESOLUTION},
        '{8'hFA, 8'h04, 8'h8B, 8'h77, K_DIST_REVISED}
    };

    // Result of a closed frame
    typedef struct packed {
        logic              done;
        logic [KIND_W-1:0] kind;
        logic              dist_load;
        logic [DIST_W-1:0] dist_val;
        logic              dist_valid;
        logic [LEN_W-1:0]  len;
    } t_frm_res;

    // Results of the busy tracker
    typedef struct packed {
        logic busy;
        logic expired;
    } t_tmr_res;

    // Kind of a non-measurement frame; first table match wins
    function automatic logic [KIND_W-1:0] ack_kind(input logic [7:0] f0,
                                                   input logic [7:0] f1,
                                                   input logic [7:0] f2,
                                                   input logic [7:0] f3);
        logic [KIND_W-1:0] k;
        k = K_UNRECOGNIZED;
        if (f0 == B_ADDR_CFG && f1 == B_FN_06 && f2 == B_PARAM && f3 == B_ADDR_MEAS) begin
            k = K_SENSOR_PARAM;
        end
        if (f0 == B_ADDR_CFG && f1 == B_FN_06 && f2 == B_MACHINE) begin
            k = K_MACHINE_NUM;
        end
        for (int i = ACK_N - 1; i >= 0; i--) begin
            if (f0 == ACK_TABLE[i].b0 && f1 == ACK_TABLE[i].b1 &&
                f2 == ACK_TABLE[i].b2 && f3 == ACK_TABLE[i].b3) begin
                k = ACK_TABLE[i].kind;
            end
        end
        return k;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= B_DIGIT_0) && (b <= B_DIGIT_9);
    endfunction

endpackage

`default_nettype wire

@@ sv/rap_frame.sv @@
`default_nettype none

module rap_frame (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic [7:0]       i_byte,
    input  wire logic             i_last,
    output rap_pkg::t_frm_res     o_res
);

    logic [rap_pkg::CNT_W-1:0] r_count;
    logic [rap_pkg::CNT_W-1:0] n_count;
    logic [7:0]                r_sum;
    logic [7:0]                r_hdr [rap_pkg::HDR_LEN];
    logic [rap_pkg::ACC_W-1:0] r_acc;
    logic [rap_pkg::ACC_W-1:0] acc_x10;
    logic                      r_dig_ok;
    logic [7:0]                f [rap_pkg::HDR_LEN];
    logic                      dig_pos;
    logic                      meas;
    logic                      is_err;
    logic                      overflow;

    // Header bytes as seen at frame end, the current byte included
    always_comb begin
        for (int i = 0; i < rap_pkg::HDR_LEN; i++) begin
            f[i] = (r_count == rap_pkg::CNT_W'(i)) ? i_byte : r_hdr[i];
        end
    end

    // Byte count after this byte; saturates one past the buffer to mark overflow
    always_comb begin
        if (r_count < rap_pkg::CNT_W'(rap_pkg::MAX_FRAME)) begin
            n_count = r_count + 1'b1;
        end else begin
            n_count = rap_pkg::CNT_W'(rap_pkg::MAX_FRAME + 1);
        end
    end

    assign dig_pos = (r_count >= rap_pkg::CNT_W'(rap_pkg::DP_INT_LO) &&
                      r_count <= rap_pkg::CNT_W'(rap_pkg::DP_INT_HI)) ||
                     (r_count >= rap_pkg::CNT_W'(rap_pkg::DP_FRAC_LO) &&
                      r_count <= rap_pkg::CNT_W'(rap_pkg::DP_FRAC_HI));

    assign acc_x10 = (r_acc << 3) + (r_acc << 1);

    assign meas = f[0] == rap_pkg::B_ADDR_MEAS && f[1] == rap_pkg::B_FN_06 &&
                  (f[2] == rap_pkg::B_SINGLE || f[2] == rap_pkg::B_CONT);
    assign is_err = n_count >= rap_pkg::CNT_W'(rap_pkg::ERR_LEN) &&
                    f[3] == rap_pkg::B_CHAR_E && f[4] == rap_pkg::B_CHAR_R &&
                    f[5] == rap_pkg::B_CHAR_R;
    assign overflow = n_count > rap_pkg::CNT_W'(rap_pkg::MAX_FRAME);

    // Frame-end classification
    always_comb begin
        o_res            = '0;
        o_res.done       = i_en && i_last;
        o_res.len        = rap_pkg::LEN_W'(n_count);
        o_res.kind       = rap_pkg::K_UNRECOGNIZED;
        if (overflow) begin
            o_res.kind = rap_pkg::K_OVERFLOW;
            o_res.len  = rap_pkg::LEN_W'(rap_pkg::MAX_FRAME);
        end else if (8'(~r_sum + 8'd1) != i_byte) begin
            o_res.kind = rap_pkg::K_CHECKSUM;
        end else if (n_count < rap_pkg::CNT_W'(rap_pkg::MIN_LEN)) begin
            o_res.kind = rap_pkg::K_UNRECOGNIZED;
        end else if (meas) begin
            if (is_err) begin
                o_res.kind      = rap_pkg::K_OUT_OF_RANGE;
                o_res.dist_load = 1'b1;
                o_res.dist_val  = '1;
            end else if (r_dig_ok && n_count == rap_pkg::CNT_W'(rap_pkg::LEN_COARSE)) begin
                o_res.kind       = (f[2] == rap_pkg::B_SINGLE) ? rap_pkg::K_SINGLE_COARSE
                                                              : rap_pkg::K_CONT_COARSE;
                o_res.dist_load  = 1'b1;
                o_res.dist_valid = 1'b1;
                o_res.dist_val   = rap_pkg::DIST_W'(acc_x10);
            end else if (r_dig_ok && n_count == rap_pkg::CNT_W'(rap_pkg::LEN_FINE)) begin
                o_res.kind       = ((f[2] == rap_pkg::B_SINGLE) ? rap_pkg::K_SINGLE_COARSE
                                                               : rap_pkg::K_CONT_COARSE)
                                   + rap_pkg::KIND_W'(1);
                o_res.dist_load  = 1'b1;
                o_res.dist_valid = 1'b1;
                o_res.dist_val   = rap_pkg::DIST_W'(r_acc);
            end else begin
                o_res.kind = rap_pkg::K_MALFORMED;
            end
        end else begin
            o_res.kind = rap_pkg::ack_kind(f[0], f[1], f[2], f[3]);
        end
    end

    // Header store, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_en && r_count < rap_pkg::CNT_W'(rap_pkg::HDR_LEN)) begin
            r_hdr[r_count[rap_pkg::HDR_IDX_W-1:0]] <= i_byte;
        end
    end

    // Count, running sum and digit accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_sum    <= '0;
            r_acc    <= '0;
            r_dig_ok <= 1'b1;
        end else if (i_en) begin
            if (i_last) begin
                r_count  <= '0;
                r_sum    <= '0;
                r_acc    <= '0;
                r_dig_ok <= 1'b1;
            end else begin
                r_count <= n_count;
                r_sum   <= r_sum + i_byte;
                if (dig_pos) begin
                    r_acc    <= acc_x10 + rap_pkg::ACC_W'(i_byte[3:0]);
                    r_dig_ok <= r_dig_ok && rap_pkg::is_digit(i_byte);
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/rap_timer.sv @@
`default_nettype none

module rap_timer (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_issue,
    input  wire logic                     i_tick,
    input  wire logic                     i_frame_end,
    input  wire logic [rap_pkg::TMO_W-1:0] i_timeout,
    output rap_pkg::t_tmr_res             o_res
);

    logic                       r_wait;
    logic [rap_pkg::TICK_W-1:0] r_ticks;
    logic [rap_pkg::TICK_W-1:0] n_ticks;

    // Saturating tick count, compared against twice the timeout
    assign n_ticks = (r_ticks == rap_pkg::TICK_MAX) ? r_ticks : r_ticks + 1'b1;

    assign o_res = '{busy:    i_issue && r_wait,
                     expired: i_tick && r_wait && (n_ticks > {i_timeout, 1'b0})};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait  <= 1'b0;
            r_ticks <= '0;
        end else begin
            if (i_issue && !r_wait) begin
                r_wait  <= 1'b1;
                r_ticks <= '0;
            end
            if (i_tick && r_wait) begin
                r_ticks <= n_ticks;
                if (o_res.expired) begin
                    r_wait <= 1'b0;
                end
            end
            if (i_frame_end) begin
                r_wait <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/rangefinder_answer_parser.sv @@
// A request passes through the input register and then the result register on its way to the master side.
// Throughput: one request per cycle; the input register and result register
// each advance whenever the result register is empty or being taken.
// Reset (i_rst_n, synchronous, active low) empties both registers, the frame
// count, sum and busy flag, clears the stored distance and sets the timeout to 1000.
`default_nettype none

module rangefinder_answer_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Request stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    input  wire logic        i_s_axis_tlast,   // frame_end
    input  wire logic [1:0]  i_s_axis_tuser,   // [1:0] command
    // Result stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,   // [24:0] distance, [29:25] frame_length
    output logic [5:0]       o_m_axis_tuser,   // [4:0] answer_kind, [5] distance_valid
    // Configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [rap_pkg::TMO_W-1:0] TMO_RESET = 16'd1000;

    logic                               r_in_vld;
    logic [1:0]                         r_in_cmd;
    logic [7:0]                         r_in_byte;
    logic                               r_in_last;
    logic                               r_out_vld;
    logic [rap_pkg::KIND_W-1:0]         r_out_kind;
    logic [rap_pkg::DIST_W-1:0]         r_out_dist;
    logic                               r_out_dv;
    logic [rap_pkg::LEN_W-1:0]          r_out_len;
    logic [rap_pkg::DIST_W-1:0]         r_distance;
    logic [rap_pkg::DIST_W-1:0]         n_distance;
    logic [rap_pkg::TMO_W-1:0]          r_timeout;
    logic                               advance;
    logic                               en_byte;
    logic                               en_issue;
    logic                               en_tick;
    logic                               res_vld;
    logic [rap_pkg::KIND_W-1:0]         res_kind;
    logic [rap_pkg::LEN_W-1:0]          res_len;
    rap_pkg::t_frm_res                  frm_res;
    rap_pkg::t_tmr_res                  tmr_res;

    // Handshake
    assign advance         = r_in_vld && (!r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_vld || advance;

    always_comb begin
        en_byte  = 1'b0;
        en_issue = 1'b0;
        en_tick  = 1'b0;
        case (r_in_cmd)
            rap_pkg::CMD_BYTE:  en_byte  = advance;
            rap_pkg::CMD_ISSUE: en_issue = advance;
            rap_pkg::CMD_TICK:  en_tick  = advance;
            default: ;
        endcase
    end

    rap_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en_byte),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_res   (frm_res)
    );

    rap_timer u_timer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_issue     (en_issue),
        .i_tick      (en_tick),
        .i_frame_end (frm_res.done),
        .i_timeout   (r_timeout),
        .o_res       (tmr_res)
    );

    // Merge the one result this request may give
    always_comb begin
        res_vld    = frm_res.done || tmr_res.busy || tmr_res.expired;
        res_kind   = frm_res.kind;
        res_len    = frm_res.len;
        n_distance = r_distance;
        if (tmr_res.busy) begin
            res_kind = rap_pkg::K_BUSY;
            res_len  = '0;
        end else if (tmr_res.expired) begin
            res_kind = rap_pkg::K_TIMEOUT;
            res_len  = '0;
        end
        if (frm_res.done && frm_res.dist_load) begin
            n_distance = frm_res.dist_val;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_cmd  <= i_s_axis_tuser;
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    // Result register and stored distance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_distance <= '0;
        end else if (advance) begin
            r_out_vld  <= res_vld;
            r_distance <= n_distance;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_kind <= res_kind;
            r_out_dist <= n_distance;
            r_out_dv   <= frm_res.done && frm_res.dist_valid;
            r_out_len  <= res_len;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {2'b00, r_out_len, r_out_dist};
    assign o_m_axis_tuser  = {r_out_dv, r_out_kind};

    // Timeout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TMO_RESET;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_timeout <= pwdata[rap_pkg::TMO_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {16'd0, r_timeout};

endmodule

`default_nettype wire
